// ===== design/meab_pkg.sv =====
// Shared types and constants of the mesh edge adjacency builder.
// No dependencies; used by every design file except meab_ram.
package meab_pkg;

  localparam int DEF_MAX_NODES     = 4096;
  localparam int DEF_MAX_EDGES     = 8192;
  localparam int DEF_MAX_NEIGHBORS = 8;

  localparam int NODE_W  = 12;
  localparam int EID_W   = 13;
  localparam int SLOT_W  = 3;
  localparam int CAP_W   = 14;
  localparam int DEG_O_W = 4;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 14'd8192;
  localparam int OPQ_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_RDNODE = 2'd1,
    ACT_RDEDGE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EDGEFULL = 2'd1,
    ST_NODEFULL = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // One unit of back-end work: an ordered edge, a read or a clear.
  typedef struct packed {
    action_t             kind;
    logic [NODE_W-1:0]   lo;
    logic [NODE_W-1:0]   hi;
    logic [SLOT_W-1:0]   slot;
    logic [EID_W-1:0]    eidx;
    logic                last;
  } op_t;

  typedef struct packed {
    logic [EID_W-1:0]   edge_id;
    logic [NODE_W-1:0]  end_low;
    logic [NODE_W-1:0]  end_high;
    logic               is_new;
    logic [NODE_W-1:0]  neighbor_node;
    logic [DEG_O_W-1:0] node_degree;
    logic [CAP_W-1:0]   total_edges;
    status_t            status;
    logic               last;
  } res_t;

endpackage

// ===== design/meab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module meab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/meab_front.sv =====
// Front end: accepts input transactions, splits a triangle into three ordered
// edges and queues work for the back end. Depends on meab_pkg.
module meab_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_action,
  input  logic [meab_pkg::NODE_W-1:0] in_node_a,
  input  logic [meab_pkg::NODE_W-1:0] in_node_b,
  input  logic [meab_pkg::NODE_W-1:0] in_node_c,
  input  logic [meab_pkg::SLOT_W-1:0] in_slot,
  input  logic [meab_pkg::EID_W-1:0]  in_edge_index,
  output logic                       op_valid,
  output meab_pkg::op_t              op_head,
  input  logic                       op_pop
);

  localparam int QD = meab_pkg::OPQ_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  meab_pkg::op_t q_r [QD];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                        tri_busy_r, tri_busy_nxt;
  logic [1:0]                  step_r, step_nxt;
  logic [meab_pkg::NODE_W-1:0] ta_r, tb_r, tc_r;

  logic                        q_full, acc, push;
  meab_pkg::op_t               push_op;
  logic [meab_pkg::NODE_W-1:0] p, q;

  assign q_full   = (cnt_r == CW'(QD));
  assign in_full  = tri_busy_r || q_full;
  assign acc      = in_push && !in_full;
  assign op_valid = (cnt_r != '0);
  assign op_head  = q_r[rp_r];

  always_comb begin
    unique case (step_r)
      2'd0:    begin p = ta_r; q = tb_r; end
      2'd1:    begin p = tb_r; q = tc_r; end
      default: begin p = tc_r; q = ta_r; end
    endcase
  end

  always_comb begin
    push         = 1'b0;
    push_op      = '0;
    tri_busy_nxt = tri_busy_r;
    step_nxt     = step_r;
    if (tri_busy_r) begin
      if (!q_full) begin
        push         = 1'b1;
        push_op.kind = meab_pkg::ACT_ADD;
        push_op.lo   = (p < q) ? p : q;
        push_op.hi   = (p < q) ? q : p;
        push_op.last = (step_r == 2'd2);
        step_nxt     = step_r + 2'd1;
        if (step_r == 2'd2) begin
          tri_busy_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      if (meab_pkg::action_t'(in_action) == meab_pkg::ACT_ADD) begin
        tri_busy_nxt = 1'b1;
        step_nxt     = 2'd0;
      end else begin
        push         = 1'b1;
        push_op.kind = meab_pkg::action_t'(in_action);
        push_op.lo   = in_node_a;
        push_op.slot = in_slot;
        push_op.eidx = in_edge_index;
        push_op.last = 1'b1;
      end
    end
  end

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = (op_pop && op_valid) ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(op_pop && op_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
      tri_busy_r <= 1'b0;
      step_r     <= 2'd0;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      cnt_r      <= cnt_nxt;
      tri_busy_r <= tri_busy_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_op;
    end
    if (acc && !tri_busy_r) begin
      ta_r <= in_node_a;
      tb_r <= in_node_b;
      tc_r <= in_node_c;
    end
  end

endmodule

// ===== design/meab_back.sv =====
// Back end: runs queued edges, reads and clears against the degree, list and
// edge memories; holds the capacity register and the result register.
// Depends on meab_pkg and meab_ram.
module meab_back #(
  parameter int MAX_NODES     = meab_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES     = meab_pkg::DEF_MAX_EDGES,
  parameter int MAX_NEIGHBORS = meab_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  input  meab_pkg::op_t               op_head,
  output logic                        op_pop,
  input  logic                        cfg_wr_en,
  input  logic [meab_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                        out_pop,
  output logic                        out_empty,
  output meab_pkg::res_t              res
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NAW = $clog2(MAX_NODES * MAX_NEIGHBORS);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int DW  = $clog2(MAX_NEIGHBORS + 1);
  localparam int BW  = (CW > meab_pkg::CAP_W) ? CW : meab_pkg::CAP_W;
  localparam int LW  = meab_pkg::NODE_W + meab_pkg::EID_W;
  localparam int EW  = 2 * meab_pkg::NODE_W;

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_DISP = 16'h0004,
    S_ELO  = 16'h0008,
    S_EHI  = 16'h0010,
    S_SRD  = 16'h0020,
    S_SCK  = 16'h0040,
    S_DEC  = 16'h0080,
    S_WLO  = 16'h0100,
    S_WHI  = 16'h0200,
    S_NDEG = 16'h0400,
    S_NRD  = 16'h0800,
    S_ERD  = 16'h1000,
    S_OUT  = 16'h2000
  } state_t;

  state_t state_r, state_nxt;
  meab_pkg::op_t op_r;
  logic [meab_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] dlo_r, dlo_nxt, dhi_r, dhi_nxt, k_r, k_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  meab_pkg::res_t pend_r, pend_nxt, res_r, res_ld;
  logic          oval_r, oval_nxt, load;

  // memory ports
  logic            deg_we;
  logic [NW-1:0]   deg_wa, deg_ra;
  logic [DW-1:0]   deg_wd, deg_rd;
  logic            nbr_we;
  logic [NAW-1:0]  nbr_wa, nbr_ra;
  logic [LW-1:0]   nbr_wd, nbr_rd;
  logic            edg_we;
  logic [EAW-1:0]  edg_wa, edg_ra;
  logic [EW-1:0]   edg_wd, edg_rd;

  logic [NW-1:0]   lo_n, hi_n;
  logic [DW-1:0]   need, dh;
  logic            tbl_full;

  meab_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (
    .clk, .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd)
  );
  meab_ram #(.WIDTH(LW), .DEPTH(MAX_NODES * MAX_NEIGHBORS)) u_nbr (
    .clk, .we(nbr_we), .waddr(nbr_wa), .wdata(nbr_wd), .raddr(nbr_ra), .rdata(nbr_rd)
  );
  meab_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edg (
    .clk, .we(edg_we), .waddr(edg_wa), .wdata(edg_wd), .raddr(edg_ra), .rdata(edg_rd)
  );

  assign lo_n     = NW'(op_r.lo);
  assign hi_n     = NW'(op_r.hi);
  assign need     = (op_r.lo == op_r.hi) ? DW'(2) : DW'(1);
  assign dh       = (op_r.lo == op_r.hi) ? dlo_r + DW'(1) : dhi_r;
  assign tbl_full = (BW'(cnt_r) >= BW'(cap_r)) || (cnt_r >= CW'(MAX_EDGES));

  assign out_empty = !oval_r;
  assign res       = res_r;
  assign load      = (state_r == S_OUT) && (!oval_r || out_pop);

  function automatic logic [NAW-1:0] list_addr(input logic [NW-1:0] n,
                                               input logic [DW-1:0] s);
    list_addr = NAW'(NAW'(n) * NAW'(MAX_NEIGHBORS)) + NAW'(s);
  endfunction

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    dlo_nxt      = dlo_r;
    dhi_nxt      = dhi_r;
    k_nxt        = k_r;
    clr_nxt      = clr_r;
    clr_pend_nxt = clr_pend_r;
    pend_nxt     = pend_r;
    op_pop       = 1'b0;
    deg_we = 1'b0; deg_wa = '0; deg_wd = '0; deg_ra = lo_n;
    nbr_we = 1'b0; nbr_wa = '0; nbr_wd = '0; nbr_ra = '0;
    edg_we = 1'b0; edg_wa = '0; edg_wd = '0; edg_ra = EAW'(op_r.eidx);

    unique case (state_r)
      S_CLR: begin
        deg_we  = 1'b1;
        deg_wa  = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == NW'(MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (op_valid) begin
          op_pop    = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        pend_nxt      = '0;
        pend_nxt.last = op_r.last;
        unique case (op_r.kind)
          meab_pkg::ACT_ADD: begin
            pend_nxt.end_low  = op_r.lo;
            pend_nxt.end_high = op_r.hi;
            if (32'(op_r.hi) >= MAX_NODES) begin
              pend_nxt.status = meab_pkg::ST_RANGE;
              state_nxt       = S_OUT;
            end else begin
              state_nxt = S_ELO;
            end
          end
          meab_pkg::ACT_RDNODE: begin
            if (32'(op_r.lo) >= MAX_NODES) begin
              pend_nxt.status = meab_pkg::ST_RANGE;
              state_nxt       = S_OUT;
            end else begin
              state_nxt = S_NDEG;
            end
          end
          meab_pkg::ACT_RDEDGE: begin
            pend_nxt.edge_id = op_r.eidx;
            if (BW'(op_r.eidx) >= BW'(cnt_r) || 32'(op_r.eidx) >= MAX_EDGES) begin
              pend_nxt.status = meab_pkg::ST_RANGE;
              state_nxt       = S_OUT;
            end else begin
              state_nxt = S_ERD;
            end
          end
          default: begin
            cnt_nxt      = '0;
            clr_pend_nxt = 1'b1;
            state_nxt    = S_OUT;
          end
        endcase
      end
      S_ELO: begin
        dlo_nxt   = deg_rd;
        deg_ra    = hi_n;
        state_nxt = S_EHI;
      end
      S_EHI: begin
        dhi_nxt   = deg_rd;
        k_nxt     = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        // walk the low node's list; the edge exists iff hi is a neighbor
        nbr_ra = list_addr(lo_n, k_r);
        state_nxt = (k_r < dlo_r) ? S_SCK : S_DEC;
      end
      S_SCK: begin
        if (nbr_rd[LW-1 -: meab_pkg::NODE_W] == op_r.hi) begin
          pend_nxt.edge_id = nbr_rd[meab_pkg::EID_W-1:0];
          state_nxt        = S_OUT;
        end else begin
          k_nxt     = k_r + DW'(1);
          state_nxt = S_SRD;
        end
      end
      S_DEC: begin
        if (tbl_full) begin
          pend_nxt.status = meab_pkg::ST_EDGEFULL;
          state_nxt       = S_OUT;
        end else if (32'(dlo_r) + 32'(need) > MAX_NEIGHBORS ||
                     32'(dhi_r) + 32'(need) > MAX_NEIGHBORS) begin
          pend_nxt.status = meab_pkg::ST_NODEFULL;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_WLO;
        end
      end
      S_WLO: begin
        nbr_we = 1'b1;
        nbr_wa = list_addr(lo_n, dlo_r);
        nbr_wd = {op_r.hi, meab_pkg::EID_W'(cnt_r)};
        deg_we = 1'b1;
        deg_wa = lo_n;
        deg_wd = dlo_r + DW'(1);
        edg_we = 1'b1;
        edg_wa = EAW'(cnt_r);
        edg_wd = {op_r.lo, op_r.hi};
        state_nxt = S_WHI;
      end
      S_WHI: begin
        nbr_we = 1'b1;
        nbr_wa = list_addr(hi_n, dh);
        nbr_wd = {op_r.lo, meab_pkg::EID_W'(cnt_r)};
        deg_we = 1'b1;
        deg_wa = hi_n;
        deg_wd = dh + DW'(1);
        pend_nxt.edge_id = meab_pkg::EID_W'(cnt_r);
        pend_nxt.is_new  = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_OUT;
      end
      S_NDEG: begin
        dlo_nxt              = deg_rd;
        pend_nxt.node_degree = meab_pkg::DEG_O_W'(deg_rd);
        nbr_ra = list_addr(lo_n, DW'(op_r.slot));
        if (32'(op_r.slot) >= 32'(deg_rd) || 32'(op_r.slot) >= MAX_NEIGHBORS) begin
          pend_nxt.status = meab_pkg::ST_RANGE;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        pend_nxt.edge_id       = nbr_rd[meab_pkg::EID_W-1:0];
        pend_nxt.neighbor_node = nbr_rd[LW-1 -: meab_pkg::NODE_W];
        state_nxt              = S_OUT;
      end
      S_ERD: begin
        pend_nxt.end_low  = edg_rd[EW-1 -: meab_pkg::NODE_W];
        pend_nxt.end_high = edg_rd[meab_pkg::NODE_W-1:0];
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          clr_nxt      = '0;
          clr_pend_nxt = 1'b0;
          state_nxt    = clr_pend_r ? S_CLR : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_pop && oval_r) begin
      oval_nxt = 1'b0;
    end
  end

  always_comb begin
    res_ld             = pend_r;
    res_ld.total_edges = meab_pkg::CAP_W'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      cnt_r      <= '0;
      clr_r      <= '0;
      clr_pend_r <= 1'b0;
      oval_r     <= 1'b0;
      cap_r      <= meab_pkg::CAP_RESET;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_r      <= clr_nxt;
      clr_pend_r <= clr_pend_nxt;
      oval_r     <= oval_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dlo_r  <= dlo_nxt;
    dhi_r  <= dhi_nxt;
    k_r    <= k_nxt;
    pend_r <= pend_nxt;
    if (op_pop) begin
      op_r <= op_head;
    end
    if (load) begin
      res_r <= res_ld;
    end
  end

endmodule

// ===== design/mesh_edge_adjacency_builder.sv =====
// Top level of the mesh edge adjacency builder.
// Depends on meab_pkg, meab_front, meab_back (and meab_ram through it).
//
// Triangles come in as three node indices and leave as three results, one
// per edge (a,b), (b,c), (c,a); reads and clear give one result. An edge is
// found by walking the low node's neighbor list in a RAM. After reset and
// after each clear, the degree memory is swept, one node per cycle, over all
// MAX_NODES nodes (4096 by default) before the next queued item is worked
// on. A small queue sits between input decode and the engine, and one result
// register at the output, so input and output stall independently.
module mesh_edge_adjacency_builder #(
  parameter int MAX_NODES     = meab_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES     = meab_pkg::DEF_MAX_EDGES,
  parameter int MAX_NEIGHBORS = meab_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [1:0]                   in_action,
  input  logic [meab_pkg::NODE_W-1:0]  in_node_a,
  input  logic [meab_pkg::NODE_W-1:0]  in_node_b,
  input  logic [meab_pkg::NODE_W-1:0]  in_node_c,
  input  logic [meab_pkg::SLOT_W-1:0]  in_slot,
  input  logic [meab_pkg::EID_W-1:0]   in_edge_index,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [meab_pkg::EID_W-1:0]   out_edge_id,
  output logic [meab_pkg::NODE_W-1:0]  out_end_low,
  output logic [meab_pkg::NODE_W-1:0]  out_end_high,
  output logic                         out_is_new,
  output logic [meab_pkg::NODE_W-1:0]  out_neighbor_node,
  output logic [meab_pkg::DEG_O_W-1:0] out_node_degree,
  output logic [meab_pkg::CAP_W-1:0]   out_total_edges,
  output logic [meab_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [meab_pkg::CAP_W-1:0]   cfg_wr_data
);

  logic           op_valid, op_pop;
  meab_pkg::op_t  op_head;
  meab_pkg::res_t res;

  meab_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_action, .in_node_a, .in_node_b,
    .in_node_c, .in_slot, .in_edge_index, .op_valid, .op_head, .op_pop
  );

  meab_back #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_back (
    .clk, .rst_n, .op_valid, .op_head, .op_pop, .cfg_wr_en, .cfg_wr_data,
    .out_pop, .out_empty, .res
  );

  assign out_edge_id       = res.edge_id;
  assign out_end_low       = res.end_low;
  assign out_end_high      = res.end_high;
  assign out_is_new        = res.is_new;
  assign out_neighbor_node = res.neighbor_node;
  assign out_node_degree   = res.node_degree;
  assign out_total_edges   = res.total_edges;
  assign out_status        = res.status;
  assign out_last          = res.last;

endmodule

// ===== design/meab_checker.sv =====
// Port-level checks for mesh_edge_adjacency_builder, bound to the top level.
// Depends on meab_pkg.
module meab_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_empty,
  input logic                         out_pop,
  input logic [meab_pkg::NODE_W-1:0]  out_end_low,
  input logic [meab_pkg::NODE_W-1:0]  out_end_high,
  input logic                         out_is_new,
  input logic [meab_pkg::CAP_W-1:0]   out_total_edges,
  input logic [meab_pkg::STAT_W-1:0]  out_status
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result present right after reset");

  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_new) |-> (out_status == meab_pkg::ST_OK))
    else $error("new edge with error status");

  a_new_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_new) |-> (out_end_low <= out_end_high))
    else $error("new edge endpoints out of order");

  a_new_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_new) |-> (out_total_edges != '0))
    else $error("new edge but edge total is zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_total_edges)))
    else $error("stalled transaction changed");

endmodule

bind mesh_edge_adjacency_builder meab_checker u_meab_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_end_low, .out_end_high, .out_is_new,
  .out_total_edges, .out_status
);
